// ----- hw/rtl/pvrm_pkg.sv -----
// Shared constants, types and register codes for the PCM voice resample mixer.
package pvrm_pkg;

   localparam int FRAME_INDEX_BITS      = 16;
   localparam int MAX_OUTPUTS_PER_FRAME = 16;

   // Only the low sixteen bits of the frame index take part in the compare.
   localparam int IDX_BITS = (FRAME_INDEX_BITS < 16) ? FRAME_INDEX_BITS : 16;
   localparam int CNT_BITS = $clog2(MAX_OUTPUTS_PER_FRAME + 1);
   localparam logic [CNT_BITS-1:0] CNT_LIMIT = CNT_BITS'(MAX_OUTPUTS_PER_FRAME);

   localparam int SAMPLE_BITS   = 16;
   localparam int STEP_BITS     = 20;
   localparam int VOLUME_BITS   = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic signed [8:0]  U8_OFFSET  = 9'sd128;
   localparam logic signed [15:0] SAMPLE_MAX = 16'sd32767;
   localparam logic signed [15:0] SAMPLE_MIN = -16'sd32768;

   typedef enum logic [2:0] {
      REG_ENABLE        = 3'd0,
      REG_SIXTEEN_BIT   = 3'd1,
      REG_STEREO        = 3'd2,
      REG_STEP          = 3'd3,
      REG_VOICE_VOLUME  = 3'd4,
      REG_MASTER_VOLUME = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic                   enable;
      logic                   sixteen_bit;
      logic                   stereo;
      logic [STEP_BITS-1:0]   step;
      logic [VOLUME_BITS-1:0] voice_volume;
      logic [VOLUME_BITS-1:0] master_volume;
   } cfg_type;

   typedef struct packed {
      logic load;    // latch the input item and its mono sample
      logic mul1;    // sample times voice volume
      logic mul2;    // scaled sample times master volume
      logic emit;    // push one result into the output register
      logic finish;  // close the frame: snap position, advance index, or rewind both at buffer end
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic hit;       // another result is due for this frame
      logic out_free;  // output register can take a result this cycle
   } status_type;

endpackage

// ----- hw/rtl/pvrm_if.sv -----
// Valid/ready channel interfaces for input frames and output samples.
interface pvrm_req_if;
   import pvrm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] left_raw;
   logic [SAMPLE_BITS-1:0] right_raw;
   logic                   partial;
   logic                   end_of_buffer;

   modport source (output valid, left_raw, right_raw, partial, end_of_buffer, input ready);
   modport sink   (input valid, left_raw, right_raw, partial, end_of_buffer, output ready);
endinterface

interface pvrm_rsp_if;
   import pvrm_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          last;

   modport source (output valid, sample, last, input ready);
   modport sink   (input valid, sample, last, output ready);
endinterface

// ----- hw/rtl/pvrm_csr.sv -----
// APB-style configuration register file.
module pvrm_csr
   import pvrm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_strobe;

   assign pready       = 1'b1;
   assign write_strobe = psel && penable && pwrite;
   assign reg_index    = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (write_strobe) begin
         case (reg_index)
            REG_ENABLE:        cfg_in.enable        = pwdata[0];
            REG_SIXTEEN_BIT:   cfg_in.sixteen_bit   = pwdata[0];
            REG_STEREO:        cfg_in.stereo        = pwdata[0];
            REG_STEP:          cfg_in.step          = pwdata[STEP_BITS-1:0];
            REG_VOICE_VOLUME:  cfg_in.voice_volume  = pwdata[VOLUME_BITS-1:0];
            REG_MASTER_VOLUME: cfg_in.master_volume = pwdata[VOLUME_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.sixteen_bit   <= 1'b1;
         cfg_ff.stereo        <= 1'b0;
         cfg_ff.step          <= STEP_BITS'(65536);
         cfg_ff.voice_volume  <= VOLUME_BITS'(32768);
         cfg_ff.master_volume <= VOLUME_BITS'(32768);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_ENABLE:        prdata = CSR_DATA_BITS'(cfg_ff.enable);
         REG_SIXTEEN_BIT:   prdata = CSR_DATA_BITS'(cfg_ff.sixteen_bit);
         REG_STEREO:        prdata = CSR_DATA_BITS'(cfg_ff.stereo);
         REG_STEP:          prdata = CSR_DATA_BITS'(cfg_ff.step);
         REG_VOICE_VOLUME:  prdata = CSR_DATA_BITS'(cfg_ff.voice_volume);
         REG_MASTER_VOLUME: prdata = CSR_DATA_BITS'(cfg_ff.master_volume);
         default:           prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/pvrm_ctrl.sv -----
// Sequencing state machine: accept, two multiply steps, emit loop, close-out.
module pvrm_ctrl
   import pvrm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL1 = 4'b0010,
      S_MUL2 = 4'b0100,
      S_EMIT = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.enable) begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (status.hit) begin
               cmd.emit = status.out_free;
            end else begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/pvrm_datapath.sv -----
// Sample decode, two-step gain multiply, saturation, position tracking, output register.
module pvrm_datapath
   import pvrm_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  cfg_type                       cfg,
   input  logic [SAMPLE_BITS-1:0]        req_left_raw,
   input  logic [SAMPLE_BITS-1:0]        req_right_raw,
   input  logic                          req_partial,
   input  logic                          req_end_of_buffer,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample,
   output logic                          rsp_last
);

   // Decode of the incoming frame to one mono sample.
   logic signed [8:0]  l8, r8;
   logic signed [9:0]  sum8, adj8, half8;
   logic signed [16:0] sum16, adj16, half16;
   logic signed [15:0] mono_in;
   logic [7:0]         mono8;

   // Gain path.
   logic signed [15:0] sample_ff;
   logic signed [33:0] prod_ff, prod_in;
   logic signed [33:0] biased, shifted;
   logic signed [16:0] a_val;
   logic signed [15:0] sat_val;

   // Position tracking.
   logic [31:0]          pos_ff, pos_in, next_pos;
   logic [IDX_BITS-1:0]  frame_ff, frame_in;
   logic [CNT_BITS-1:0]  count_ff, count_in, count_next;
   logic                 eob_ff;
   logic                 pos_in_frame, next_hit;

   // Output register.
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_sample_ff;
   logic                          out_last_ff;

   always_comb begin
      l8     = $signed({1'b0, req_left_raw[7:0]}) - U8_OFFSET;
      r8     = $signed({1'b0, req_right_raw[7:0]}) - U8_OFFSET;
      sum8   = {l8[8], l8} + {r8[8], r8};
      // Halving rounds toward zero: odd negative sums are nudged up first.
      adj8   = sum8 + 10'(sum8[9] & sum8[0]);
      half8  = adj8 >>> 1;
      mono8  = cfg.stereo ? half8[7:0] : l8[7:0];

      sum16  = {req_left_raw[15], req_left_raw} + {req_right_raw[15], req_right_raw};
      adj16  = sum16 + 17'(sum16[16] & sum16[0]);
      half16 = adj16 >>> 1;

      if (req_partial) begin
         mono_in = '0;
      end else if (cfg.sixteen_bit) begin
         mono_in = cfg.stereo ? half16[15:0] : req_left_raw;
      end else begin
         mono_in = {mono8, 8'h00};
      end
   end

   // Divide by 32768 toward zero on whatever product is held.
   always_comb begin
      biased  = prod_ff + (prod_ff[33] ? 34'sd32767 : 34'sd0);
      shifted = biased >>> 15;
      a_val   = shifted[16:0];
      if (shifted > 34'(SAMPLE_MAX)) begin
         sat_val = SAMPLE_MAX;
      end else if (shifted < 34'(SAMPLE_MIN)) begin
         sat_val = SAMPLE_MIN;
      end else begin
         sat_val = shifted[15:0];
      end
   end

   always_comb begin
      prod_in = prod_ff;
      if (cmd.mul1) begin
         prod_in = sample_ff * $signed({1'b0, cfg.voice_volume});
      end else if (cmd.mul2) begin
         prod_in = a_val * $signed({1'b0, cfg.master_volume});
      end
   end

   always_comb begin
      pos_in_frame = (pos_ff[16 +: IDX_BITS] == frame_ff);
      next_pos     = pos_ff + 32'(cfg.step);
      count_next   = count_ff + CNT_BITS'(1);
      next_hit     = (next_pos[16 +: IDX_BITS] == frame_ff) && (count_next < CNT_LIMIT);

      status.enable   = cfg.enable;
      status.hit      = pos_in_frame && (count_ff < CNT_LIMIT);
      status.out_free = !out_valid_ff || rsp_ready;

      pos_in   = pos_ff;
      frame_in = frame_ff;
      count_in = count_ff;
      if (cmd.load) begin
         count_in = '0;
      end
      if (cmd.emit) begin
         pos_in   = next_pos;
         count_in = count_next;
      end
      if (cmd.finish) begin
         if (eob_ff) begin
            pos_in   = '0;
            frame_in = '0;
         end else begin
            // Out of outputs but still inside this frame: jump to the next frame start.
            if (pos_in_frame) begin
               pos_in = {pos_ff[31:16] + 16'd1, 16'h0000};
            end
            frame_in = frame_ff + IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         frame_ff     <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         frame_ff <= frame_in;
         count_ff <= count_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sample_ff <= mono_in;
         eob_ff    <= req_end_of_buffer;
      end
      prod_ff <= prod_in;
      if (cmd.emit) begin
         out_sample_ff <= sat_val;
         out_last_ff   <= !next_hit;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_sample_ff;
   assign rsp_last   = out_last_ff;

endmodule

// ----- hw/rtl/pcm_voice_resample_mixer.sv -----
// Top level of the PCM voice resample mixer: channels, register port and assertions.
//
// The req channel carries one source frame per item (left_raw, right_raw, partial,
// end_of_buffer). The frame is reduced to one mono sample, 8-bit unsigned or 16-bit
// signed, with stereo pairs averaged toward zero. The rsp channel carries zero to
// sixteen result items per frame, each a sample scaled by voice volume and then
// master volume (unsigned Q1.15, truncating) and saturated to 16 bits; last marks
// the final result of a frame. A Q16.16 position advances by step per result, and
// results are produced while its integer part matches the current frame index.
// An item that produces n results passes through these steps in order: accept, the
// voice gain multiply, the master gain multiply, emission at one result per cycle
// while the output register can take it, and close-out of the frame. While the
// voice is disabled an item is accepted every cycle and produces nothing. The first
// result is emitted after both multiply steps. The result sits in an output
// register, so the next frame may be accepted while the last result still waits.
// If the receiver stalls, emission holds with the position frozen until the output
// register drains. Synchronous reset returns the position and frame index to zero
// and the registers to their defaults: disabled, 16-bit mono, unity step and gains.
// Registers sit at byte addresses 4*i on the APB-style port; writes take effect at
// the access edge, and should be made only while the block is idle.
module pcm_voice_resample_mixer
   import pvrm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   pvrm_req_if.sink                 req,
   pvrm_rsp_if.source               rsp,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   pvrm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pvrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pvrm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg),
      .req_left_raw      (req.left_raw),
      .req_right_raw     (req.right_raw),
      .req_partial       (req.partial),
      .req_end_of_buffer (req.end_of_buffer),
      .rsp_ready         (rsp.ready),
      .rsp_valid         (rsp.valid),
      .rsp_sample        (rsp.sample),
      .rsp_last          (rsp.last)
   );

   // A result is only pushed when the output register is empty or being drained.
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp.valid || rsp.ready))
      else $error("result pushed over an untaken result");

   // The controller issues at most one datapath command per cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul1, cmd.mul2, cmd.emit, cmd.finish}))
      else $error("conflicting datapath commands");

   // Closing a frame returns the block to accepting input on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> req.ready)
      else $error("block not ready after frame close-out");

   // Input is never taken while a frame is still being processed.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.mul1 || cmd.mul2 || cmd.emit) |-> !req.ready)
      else $error("input accepted during frame processing");

endmodule

// ----- tb/sv/pcm_voice_resample_mixer_test.sv -----
// Self-checking testbench for the PCM voice resample mixer: directed table, then random buffers.
`timescale 1ns / 1ps

module pcm_voice_resample_mixer_test;
   import pvrm_pkg::*;

   // The run stops once this many frames, directed and random together, have been accepted.
   localparam int TOTAL_ITEMS    = 260;
   localparam int GAIN_UNITY     = 32768;
   localparam int SETTLE_CYCLES  = 12;
   localparam int DRAIN_LIMIT    = 20000;

   typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] left_raw;
      logic [SAMPLE_BITS-1:0] right_raw;
      logic                   partial;
      logic                   end_of_buffer;
   } voice_frame_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } mix_result_type;

   // One row of the directed table. A write row programs register idx with value. A frame row
   // sends one item; when typed is set, every sample it produces must equal want, otherwise
   // the sample comes from the gain model below.
   typedef struct packed {
      row_kind_type                  kind;
      reg_index_type                 idx;
      logic [31:0]                   value;
      logic [SAMPLE_BITS-1:0]        left_raw;
      logic [SAMPLE_BITS-1:0]        right_raw;
      logic                          partial;
      logic                          end_of_buffer;
      logic                          typed;
      logic signed [SAMPLE_BITS-1:0] want;
   } plan_row_type;

   // The directed part walks the formats, the gain extremes, a partial frame, buffer ends,
   // the disabled voice, sixteen results per frame, the output cap (a step below the legal
   // range) and the largest step, where most frames produce nothing.
   localparam int PLAN_ROWS = 37;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // Voice still disabled after reset: nothing comes out and the position stays put.
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h1234, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, REG_ENABLE,        32'd1,       16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      // 16-bit mono at unity gains passes samples straight through, one per frame; a partial frame gives zero.
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h7FFF, 16'h0000, 1'b0, 1'b0, 1'b1, 16'sd32767},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h8000, 16'h0000, 1'b0, 1'b0, 1'b1, -16'sd32768},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1, -16'sd1},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 1'b1, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h1234, 16'h0000, 1'b0, 1'b1, 1'b1, 16'sd4660},
      // Stereo averaging truncates toward zero.
      '{ROW_WRITE, REG_STEREO,        32'd1,       16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b1, 16'sd32767},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h8000, 16'h8000, 1'b0, 1'b0, 1'b1, -16'sd32768},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h0001, 16'h0000, 1'b0, 1'b0, 1'b1, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b1, 16'sd0},
      // 8-bit unsigned stereo, then mono with junk in the high byte.
      '{ROW_WRITE, REG_SIXTEEN_BIT,   32'd0,       16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h00FF, 16'hFFFF, 1'b0, 1'b0, 1'b1, 16'sd32512},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'hFF00, 16'h0000, 1'b0, 1'b0, 1'b1, -16'sd32768},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h0081, 16'h0080, 1'b0, 1'b0, 1'b1, 16'sd0},
      '{ROW_WRITE, REG_STEREO,        32'd0,       16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'hAB80, 16'h1234, 1'b0, 1'b0, 1'b1, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h5AFF, 16'h0000, 1'b0, 1'b0, 1'b1, 16'sd32512},
      // Both gains at their maximum push full-scale samples into saturation; then a zero voice gain gives silence.
      '{ROW_WRITE, REG_SIXTEEN_BIT,   32'd1,       16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, REG_VOICE_VOLUME,  32'd65535,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_WRITE, REG_MASTER_VOLUME, 32'd65535,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h7FFF, 16'h0000, 1'b0, 1'b0, 1'b1, 16'sd32767},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h8000, 16'h0000, 1'b0, 1'b1, 1'b1, -16'sd32768},
      '{ROW_WRITE, REG_VOICE_VOLUME,  32'd0,       16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h7FFF, 16'h0000, 1'b0, 1'b0, 1'b1, 16'sd0},
      '{ROW_WRITE, REG_VOICE_VOLUME,  32'd32768,   16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h4000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      // Smallest legal step: sixteen results for one frame.
      '{ROW_WRITE, REG_STEP,          32'd4096,    16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h1357, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      // A step below the legal range hits the output cap and the position snaps forward.
      '{ROW_WRITE, REG_STEP,          32'd2048,    16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h8642, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h0F0F, 16'h0000, 1'b0, 1'b1, 1'b0, 16'sd0},
      // Largest step: one result, then a frame that produces nothing.
      '{ROW_WRITE, REG_STEP,          32'd1048575, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h2222, 16'h0000, 1'b0, 1'b0, 1'b0, 16'sd0},
      '{ROW_FRAME, REG_ENABLE,        32'd0,       16'h4444, 16'h0000, 1'b0, 1'b1, 1'b0, 16'sd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   pvrm_req_if req_ch ();
   pvrm_rsp_if rsp_ch ();

   pcm_voice_resample_mixer u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // Shadow copy of the registers, starting from their reset values.
   logic                   cfg_enable      = 1'b0;
   logic                   cfg_sixteen_bit = 1'b1;
   logic                   cfg_stereo      = 1'b0;
   logic [STEP_BITS-1:0]   cfg_step        = 20'd65536;
   logic [VOLUME_BITS-1:0] cfg_voice       = 16'd32768;
   logic [VOLUME_BITS-1:0] cfg_master      = 16'd32768;

   // Resampler state: Q16.16 output position and the index of the current source frame.
   logic [31:0]         voice_pos = '0;
   logic [IDX_BITS-1:0] frame_idx = '0;

   mix_result_type expected_mix[$];
   int             error_count   = 0;
   int             played_frames = 0;
   int             burst_left    = 0;

   function automatic void note_failure(string what);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch %0d at %0t: %s", error_count, $time, what);
      end
   endfunction

   // Reduce a frame to one mono sample and apply voice gain, then master gain, each
   // truncating toward zero, and finally clamp to the 16-bit range.
   function automatic logic signed [SAMPLE_BITS-1:0] gain_sample(voice_frame_type f);
      int     left_val;
      int     right_val;
      int     mono;
      longint voiced;
      longint mastered;
      if (f.partial) begin
         mono = 0;
      end else if (!cfg_sixteen_bit) begin
         left_val  = int'(f.left_raw[7:0]) - int'(U8_OFFSET);
         right_val = int'(f.right_raw[7:0]) - int'(U8_OFFSET);
         mono = cfg_stereo ? ((left_val + right_val) / 2) * 256 : left_val * 256;
      end else begin
         left_val  = int'($signed(f.left_raw));
         right_val = int'($signed(f.right_raw));
         mono = cfg_stereo ? (left_val + right_val) / 2 : left_val;
      end
      voiced   = (longint'(mono) * longint'(cfg_voice)) / GAIN_UNITY;
      mastered = (voiced * longint'(cfg_master)) / GAIN_UNITY;
      if (mastered > longint'(SAMPLE_MAX)) begin
         mastered = longint'(SAMPLE_MAX);
      end else if (mastered < longint'(SAMPLE_MIN)) begin
         mastered = longint'(SAMPLE_MIN);
      end
      return SAMPLE_BITS'(mastered);
   endfunction

   // Advance the resampler by one accepted frame and queue the samples it must produce.
   // Emission continues while the integer part of the position names the current frame, up
   // to the per-frame cap; a position still stuck in the frame after that is snapped to the
   // start of the next one. The end of a buffer rewinds everything to zero.
   function automatic void advance_voice(voice_frame_type f, logic typed,
                                         logic signed [SAMPLE_BITS-1:0] want);
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [31:0]                   next_pos;
      logic                          more;
      int                            count;
      mix_result_type                entry;
      if (!cfg_enable) begin
         return;
      end
      sample = typed ? want : gain_sample(f);
      count  = 0;
      while (count < MAX_OUTPUTS_PER_FRAME && voice_pos[16 +: IDX_BITS] == frame_idx) begin
         next_pos = voice_pos + 32'(cfg_step);
         more = (count + 1 < MAX_OUTPUTS_PER_FRAME) && (next_pos[16 +: IDX_BITS] == frame_idx);
         entry.sample = sample;
         entry.last   = !more;
         expected_mix.insert(expected_mix.size(), entry);
         voice_pos = next_pos;
         count++;
      end
      if (voice_pos[16 +: IDX_BITS] == frame_idx) begin
         voice_pos = {voice_pos[31:16] + 16'd1, 16'd0};
      end
      frame_idx = frame_idx + IDX_BITS'(1);
      if (f.end_of_buffer) begin
         voice_pos = '0;
         frame_idx = '0;
      end
   endfunction

   // Register write: setup cycle, then access cycle; the write lands on the edge where
   // pready is seen high. The bus is then left idle before returning, so back-to-back writes
   // never assign psel twice in the same step.
   task automatic write_register(reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_ENABLE:        cfg_enable      = value[0];
         REG_SIXTEEN_BIT:   cfg_sixteen_bit = value[0];
         REG_STEREO:        cfg_stereo      = value[0];
         REG_STEP:          cfg_step        = value[STEP_BITS-1:0];
         REG_VOICE_VOLUME:  cfg_voice       = value[VOLUME_BITS-1:0];
         REG_MASTER_VOLUME: cfg_master      = value[VOLUME_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one frame and hold it until the block takes it. The prediction is made on the
   // accepting edge, before the block has run its multiply steps and emitted the first sample.
   task automatic send_frame(voice_frame_type f, logic typed,
                             logic signed [SAMPLE_BITS-1:0] want);
      req_ch.valid         <= 1'b1;
      req_ch.left_raw      <= f.left_raw;
      req_ch.right_raw     <= f.right_raw;
      req_ch.partial       <= f.partial;
      req_ch.end_of_buffer <= f.end_of_buffer;
      do @(posedge clock); while (!req_ch.ready);
      advance_voice(f, typed, want);
      played_frames++;
   endtask

   // Stop sending and wait until every queued sample has come out. Frames that produce no
   // sample may still be in flight, so a settling wait follows before returning.
   task automatic settle_voice();
      int waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (expected_mix.size() != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Between frames: keep streaming within a burst. After a burst, now and then hold off until
   // the block has drained completely; otherwise idle for a random gap if bursty, else go on.
   task automatic sender_gap(bit bursty);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 10);
         if ($urandom_range(0, 59) == 0) begin
            settle_voice();
         end else if (bursty) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   endtask

   function automatic logic [SAMPLE_BITS-1:0] random_raw();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h00FF;
         default: return SAMPLE_BITS'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [31:0] random_gain();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'd65535;
         2, 3:    return 32'd32768;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   // Mostly steps that give one or a few samples per frame, with the extremes mixed in.
   function automatic logic [31:0] random_step();
      case ($urandom_range(0, 7))
         0:       return 32'd4096;
         1:       return 32'd1048575;
         2:       return 32'd65536;
         3:       return 32'd21845;
         4:       return $urandom_range(4096, 65536);
         5:       return $urandom_range(65536, 262144);
         6:       return $urandom_range(4096, 1048575);
         default: return 32'd32768;
      endcase
   endfunction

   // Main stimulus: directed table, then random phases. Each phase programs every register
   // while the block is idle and then plays buffers of frames; most buffers close with an
   // end-of-buffer frame, some run on into the next one or carry stray flags.
   initial begin
      voice_frame_type f;
      int              phase;
      int              phase_len;
      int              sent;
      int              buf_len;
      bit              bursty;
      bit              closing;

      req_ch.valid         <= 1'b0;
      req_ch.left_raw      <= '0;
      req_ch.right_raw     <= '0;
      req_ch.partial       <= 1'b0;
      req_ch.end_of_buffer <= 1'b0;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (PLAN[i]) begin
         if (PLAN[i].kind == ROW_WRITE) begin
            settle_voice();
            write_register(PLAN[i].idx, PLAN[i].value);
         end else begin
            f = '{PLAN[i].left_raw, PLAN[i].right_raw, PLAN[i].partial, PLAN[i].end_of_buffer};
            send_frame(f, PLAN[i].typed, PLAN[i].want);
            sender_gap(1'b1);
         end
      end
      settle_voice();

      phase = 0;
      while (played_frames < TOTAL_ITEMS && phase < 80) begin
         write_register(REG_ENABLE, ($urandom_range(0, 7) != 0) ? 32'd1 : 32'd0);
         write_register(REG_SIXTEEN_BIT, $urandom_range(0, 1));
         write_register(REG_STEREO, $urandom_range(0, 1));
         write_register(REG_STEP, random_step());
         write_register(REG_VOICE_VOLUME, random_gain());
         write_register(REG_MASTER_VOLUME, random_gain());
         bursty    = ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(20, 45);
         sent      = 0;
         while (sent < phase_len && played_frames < TOTAL_ITEMS) begin
            buf_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 12);
            for (int k = 0; k < buf_len && sent < phase_len && played_frames < TOTAL_ITEMS;
                 k++) begin
               closing           = (k == buf_len - 1);
               f.left_raw        = random_raw();
               f.right_raw       = random_raw();
               f.partial         = closing ? ($urandom_range(0, 2) == 0)
                                           : ($urandom_range(0, 24) == 0);
               f.end_of_buffer   = closing ? ($urandom_range(0, 7) != 0)
                                           : ($urandom_range(0, 39) == 0);
               send_frame(f, 1'b0, '0);
               sent++;
               sender_gap(bursty);
            end
         end
         settle_voice();
         phase++;
      end

      settle_voice();
      if (expected_mix.size() != 0) begin
         note_failure($sformatf("%0d samples never arrived", expected_mix.size()));
      end
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // The receiver changes its stall pattern after each random span: always ready, mostly
   // ready, mostly stalled, or a fixed on/off rhythm.
   initial begin
      stall_mode_type mode;
      int             span;
      int             tick;
      tick = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         span = $urandom_range(20, 150);
         repeat (span) begin
            @(posedge clock);
            tick++;
            case (mode)
               STALL_NONE:  rsp_ch.ready <= 1'b1;
               STALL_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               STALL_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp_ch.ready <= ((tick % 7) < 4);
            endcase
         end
      end
   end

   // Every sample taken from the block must match the oldest outstanding prediction.
   always @(posedge clock) begin
      mix_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_mix.size() == 0) begin
            note_failure($sformatf("unexpected sample %0d last %0b",
                                   rsp_ch.sample, rsp_ch.last));
         end else begin
            want = expected_mix.pop_front();
            if (rsp_ch.sample !== want.sample || rsp_ch.last !== want.last) begin
               note_failure($sformatf("sample exp %0d act %0d, last exp %0b act %0b",
                                      want.sample, rsp_ch.sample, want.last, rsp_ch.last));
            end
         end
      end
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/pvrm_pkg.sv
hw/rtl/pvrm_if.sv
hw/rtl/pvrm_csr.sv
hw/rtl/pvrm_ctrl.sv
hw/rtl/pvrm_datapath.sv
hw/rtl/pcm_voice_resample_mixer.sv
tb/sv/pcm_voice_resample_mixer_test.sv
